// ===== design/tct_pkg.sv =====
// Shared types, constants and helper functions for the touch contact tracker.
// Used by tct_calib and touch_contact_tracker; depends on nothing else.
package tct_pkg;

  localparam int NUM_SLOTS = 10;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  // Configuration register map (register index = byte address / 4).
  localparam int REG_COUNT = 7;
  localparam int ADDR_W    = $clog2(REG_COUNT * 4);
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_CAL_XX   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_CAL_XY   = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_CAL_XOFF = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_CAL_YX   = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_CAL_YY   = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_CAL_YOFF = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_ENABLE   = REG_IDX_W'(6);

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_NO_ROOM  = 2'd2;

  // Calibrator step codes: which product is formed.
  localparam logic [1:0] STEP_XX = 2'd0;
  localparam logic [1:0] STEP_XY = 2'd1;
  localparam logic [1:0] STEP_YX = 2'd2;
  localparam logic [1:0] STEP_YY = 2'd3;

  typedef struct packed {
    logic [7:0]  finger_id;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [11:0] pressure;
    logic        touching;
  } tct_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        has_contact;
    logic [3:0]  active_count;
    logic [7:0]  out_id;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [11:0] out_pressure;
    logic        last;
  } tct_rsp_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] x;
    logic [15:0] y;
    logic [11:0] pressure;
  } slot_entry_t;

  typedef struct packed {
    logic signed [31:0] xx;
    logic signed [31:0] xy;
    logic signed [31:0] xoff;
    logic signed [31:0] yx;
    logic signed [31:0] yy;
    logic signed [31:0] yoff;
  } cal_coef_t;

  typedef struct packed {
    logic        start;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
  } cal_cmd_t;

  typedef struct packed {
    logic        done;
    logic [15:0] x;
    logic [15:0] y;
  } cal_res_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] idx;
  } slot_pick_t;

  // Lowest set bit of a slot mask.
  function automatic slot_pick_t find_lowest(input logic [NUM_SLOTS-1:0] mask);
    slot_pick_t p;
    p.hit = 1'b0;
    p.idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        p.hit = 1'b1;
        p.idx = SLOT_W'(i);
      end
    end
    return p;
  endfunction

  function automatic logic [CNT_W-1:0] count_ones(input logic [NUM_SLOTS-1:0] mask);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      c = c + CNT_W'(mask[i]);
    end
    return c;
  endfunction

endpackage

// ===== design/tct_calib.sv =====
// Affine calibrator: four Q16.16 products through one shared multiplier,
// accumulated at 50 bits, then floored and clamped to 0..65535. Uses tct_pkg.
module tct_calib (
  input  logic                clk,
  input  logic                rst,
  input  tct_pkg::cal_coef_t  coef,
  input  tct_pkg::cal_cmd_t   cmd,
  output tct_pkg::cal_res_t   res
);

  logic               running;
  logic [1:0]         step;
  logic               prod_valid;
  logic [1:0]         prod_step;
  logic signed [48:0] prod;
  logic signed [49:0] acc_x;
  logic signed [49:0] acc_y;
  logic               done;
  logic [15:0]        raw_x;
  logic [15:0]        raw_y;

  logic signed [31:0] mul_a;
  logic signed [16:0] mul_b;

  always_comb begin
    case (step)
      tct_pkg::STEP_XX: begin
        mul_a = coef.xx;
        mul_b = signed'({1'b0, raw_x});
      end
      tct_pkg::STEP_XY: begin
        mul_a = coef.xy;
        mul_b = signed'({1'b0, raw_y});
      end
      tct_pkg::STEP_YX: begin
        mul_a = coef.yx;
        mul_b = signed'({1'b0, raw_x});
      end
      default: begin
        mul_a = coef.yy;
        mul_b = signed'({1'b0, raw_y});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      prod_valid <= 1'b0;
      done       <= 1'b0;
      step       <= tct_pkg::STEP_XX;
    end else if (cmd.start) begin
      running    <= 1'b1;
      prod_valid <= 1'b0;
      done       <= 1'b0;
      step       <= tct_pkg::STEP_XX;
    end else begin
      prod_valid <= running;
      if (running) begin
        step <= step + 2'd1;
        if (step == tct_pkg::STEP_YY) begin
          running <= 1'b0;
        end
      end
      if (prod_valid && prod_step == tct_pkg::STEP_YY) begin
        done <= 1'b1;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      raw_x <= cmd.raw_x;
      raw_y <= cmd.raw_y;
      acc_x <= {{18{coef.xoff[31]}}, coef.xoff};
      acc_y <= {{18{coef.yoff[31]}}, coef.yoff};
    end else begin
      if (running) begin
        prod      <= mul_a * mul_b;
        prod_step <= step;
      end
      if (prod_valid) begin
        if (prod_step[1]) begin
          acc_y <= acc_y + prod;
        end else begin
          acc_x <= acc_x + prod;
        end
      end
    end
  end

  // A negative sum floors below zero; anything at or above 2^32 exceeds 65535.
  function automatic logic [15:0] clamp(input logic signed [49:0] s);
    logic [15:0] v;
    if (s[49]) begin
      v = 16'h0000;
    end else if (|s[48:32]) begin
      v = 16'hFFFF;
    end else begin
      v = s[31:16];
    end
    return v;
  endfunction

  assign res.done = done;
  assign res.x    = clamp(acc_x);
  assign res.y    = clamp(acc_y);

endmodule

// ===== design/touch_contact_tracker.sv =====
// Top level of the touch contact tracker: configuration registers, slot
// table memory, search and report sequencer. Depends on tct_pkg, tct_calib.
//
//   channel   ports                              handshake
//   request   start, busy, req                   taken when start & !busy
//   result    done, result                       done marks each result, no stall
//   config    psel penable pwrite paddr pwdata   APB, pready tied high
//             prdata pready
//
// While busy, the single read port of the slot memory is walked once to search
// the ids and once more to report the table; the calibration runs alongside
// the search.
// A disabled request gives its one result in the cycle after it is taken.
// Reset clears the active-slot bits and the sequencer; the memory itself is
// not cleared. Results cannot be held off, so the sequencer never waits on
// the receiver.
module touch_contact_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  tct_pkg::tct_req_t             req,
  output logic                          done,
  output tct_pkg::tct_rsp_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tct_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_UPDATE = 5'b00100,
    S_COUNT  = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  // ---------------- configuration ----------------
  tct_pkg::cal_coef_t                coef;
  logic                              enable;
  logic [tct_pkg::REG_IDX_W-1:0]     reg_idx;
  logic                              cfg_write;

  assign reg_idx   = paddr[tct_pkg::ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.xx   <= 32'sh0001_0000;
      coef.xy   <= '0;
      coef.xoff <= '0;
      coef.yx   <= '0;
      coef.yy   <= 32'sh0001_0000;
      coef.yoff <= '0;
      enable    <= 1'b1;
    end else if (cfg_write) begin
      case (reg_idx)
        tct_pkg::REG_CAL_XX:   coef.xx   <= pwdata;
        tct_pkg::REG_CAL_XY:   coef.xy   <= pwdata;
        tct_pkg::REG_CAL_XOFF: coef.xoff <= pwdata;
        tct_pkg::REG_CAL_YX:   coef.yx   <= pwdata;
        tct_pkg::REG_CAL_YY:   coef.yy   <= pwdata;
        tct_pkg::REG_CAL_YOFF: coef.yoff <= pwdata;
        tct_pkg::REG_ENABLE:   enable    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tct_pkg::REG_CAL_XX:   prdata = coef.xx;
      tct_pkg::REG_CAL_XY:   prdata = coef.xy;
      tct_pkg::REG_CAL_XOFF: prdata = coef.xoff;
      tct_pkg::REG_CAL_YX:   prdata = coef.yx;
      tct_pkg::REG_CAL_YY:   prdata = coef.yy;
      tct_pkg::REG_CAL_YOFF: prdata = coef.yoff;
      tct_pkg::REG_ENABLE:   prdata = {31'd0, enable};
      default:               prdata = '0;
    endcase
  end

  // ---------------- registers ----------------
  state_t                          state, state_next;
  tct_pkg::tct_req_t               req_q;
  logic [tct_pkg::NUM_SLOTS-1:0]   used, used_next;
  logic [tct_pkg::NUM_SLOTS-1:0]   pend, pend_next;
  logic                            rd_valid, rd_valid_next;
  logic [tct_pkg::SLOT_W-1:0]      rd_idx;
  logic                            rd_last, rd_last_next;
  logic [tct_pkg::SLOT_W-1:0]      sel, sel_next;
  logic [tct_pkg::CNT_W-1:0]       cnt, cnt_next;
  logic                            done_next;
  tct_pkg::tct_rsp_t               result_next;

  logic                            accept;
  logic                            issue;
  logic                            mem_we;
  tct_pkg::slot_pick_t             pick;
  tct_pkg::slot_pick_t             free_pick;
  tct_pkg::slot_entry_t            rdata;
  tct_pkg::slot_entry_t            wdata;
  tct_pkg::cal_cmd_t               cal_cmd;
  tct_pkg::cal_res_t               cal_res;
  logic [tct_pkg::NUM_SLOTS-1:0]   pend_cleared;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign pick      = tct_pkg::find_lowest(pend);
  assign free_pick = tct_pkg::find_lowest(~used);

  always_comb begin
    pend_cleared           = pend;
    pend_cleared[pick.idx] = 1'b0;
  end

  assign cal_cmd.start = accept && enable;
  assign cal_cmd.raw_x = req.raw_x;
  assign cal_cmd.raw_y = req.raw_y;

  tct_calib u_calib (
    .clk  (clk),
    .rst  (rst),
    .coef (coef),
    .cmd  (cal_cmd),
    .res  (cal_res)
  );

  assign wdata.id       = req_q.finger_id;
  assign wdata.x        = cal_res.x;
  assign wdata.y        = cal_res.y;
  assign wdata.pressure = req_q.pressure;

  // ---------------- slot table memory ----------------
  // Writes happen only in the update state and reads only while searching or
  // reporting, so an access never meets a write to the same entry.
  tct_pkg::slot_entry_t slot_mem [tct_pkg::NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[sel] <= wdata;
    end
    if (issue) begin
      rdata <= slot_mem[pick.idx];
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next    = state;
    used_next     = used;
    pend_next     = pend;
    sel_next      = sel;
    cnt_next      = cnt;
    issue         = 1'b0;
    rd_valid_next = 1'b0;
    rd_last_next  = rd_last;
    mem_we        = 1'b0;
    done_next     = 1'b0;
    result_next   = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!enable) begin
            done_next          = 1'b1;
            result_next.status = tct_pkg::ST_DISABLED;
            result_next.last   = 1'b1;
          end else begin
            pend_next  = used;
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (rd_valid && rdata.id == req_q.finger_id) begin
          sel_next   = rd_idx;
          state_next = S_UPDATE;
        end else if (!pick.hit && !rd_valid) begin
          if (free_pick.hit) begin
            sel_next   = free_pick.idx;
            state_next = S_UPDATE;
          end else begin
            done_next          = 1'b1;
            result_next.status = tct_pkg::ST_NO_ROOM;
            result_next.last   = 1'b1;
            state_next         = S_IDLE;
          end
        end else if (pick.hit) begin
          issue         = 1'b1;
          rd_valid_next = 1'b1;
          pend_next     = pend_cleared;
        end
      end

      S_UPDATE: begin
        if (cal_res.done) begin
          mem_we          = req_q.touching;
          used_next[sel]  = req_q.touching;
          state_next      = S_COUNT;
        end
      end

      S_COUNT: begin
        cnt_next  = tct_pkg::count_ones(used);
        pend_next = used;
        if (used == '0) begin
          done_next          = 1'b1;
          result_next.status = tct_pkg::ST_OK;
          result_next.last   = 1'b1;
          state_next         = S_IDLE;
        end else begin
          state_next = S_EMIT;
        end
      end

      S_EMIT: begin
        if (pick.hit) begin
          issue         = 1'b1;
          rd_valid_next = 1'b1;
          rd_last_next  = (pend_cleared == '0);
          pend_next     = pend_cleared;
        end
        if (rd_valid) begin
          done_next                = 1'b1;
          result_next.status       = tct_pkg::ST_OK;
          result_next.has_contact  = 1'b1;
          result_next.active_count = 4'(cnt);
          result_next.out_id       = rdata.id;
          result_next.out_x        = rdata.x;
          result_next.out_y        = rdata.y;
          result_next.out_pressure = rdata.pressure;
          result_next.last         = rd_last;
          if (rd_last) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used     <= '0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      used     <= used_next;
      rd_valid <= rd_valid_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (issue) begin
      rd_idx <= pick.idx;
    end
    pend    <= pend_next;
    rd_last <= rd_last_next;
    sel     <= sel_next;
    cnt     <= cnt_next;
    result  <= result_next;
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for touch_contact_tracker: a contact-table predictor
// with affine calibration, a result checker and request/APB drivers.
// Depends on tct_pkg and the touch_contact_tracker RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 40;

  // Ids shared by directed and random requests; 00 and FF make every id bit toggle.
  localparam logic [11:0][7:0] CONTACT_POOL = {8'h17, 8'h16, 8'h15, 8'h14, 8'h13, 8'h12,
                                               8'h11, 8'h10, 8'hAA, 8'h55, 8'hFF, 8'h00};

  typedef enum int {CAL_NEAR_UNITY, CAL_ALL_MAX, CAL_ALL_MIN, CAL_ARBITRARY} cal_style_t;

  class snapshot_scoreboard;
    tct_pkg::cal_coef_t   coef;
    bit                   enabled;
    bit                   in_use [tct_pkg::NUM_SLOTS];
    tct_pkg::slot_entry_t slots  [tct_pkg::NUM_SLOTS];
    tct_pkg::tct_rsp_t    expected_reports [$];
    int                   failures;

    function new();
      coef.xx   = 32'sd65536;
      coef.xy   = '0;
      coef.xoff = '0;
      coef.yx   = '0;
      coef.yy   = 32'sd65536;
      coef.yoff = '0;
      enabled   = 1'b1;
      failures  = 0;
      foreach (slots[i]) begin
        slots[i]  = '0;
        in_use[i] = 1'b0;
      end
    endfunction

    function void set_register(logic [tct_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        tct_pkg::REG_CAL_XX:   coef.xx = value;
        tct_pkg::REG_CAL_XY:   coef.xy = value;
        tct_pkg::REG_CAL_XOFF: coef.xoff = value;
        tct_pkg::REG_CAL_YX:   coef.yx = value;
        tct_pkg::REG_CAL_YY:   coef.yy = value;
        tct_pkg::REG_CAL_YOFF: coef.yoff = value;
        tct_pkg::REG_ENABLE:   enabled = value[0];
        default: ;
      endcase
    endfunction

    // Exact floor of the Q16.16 sum, then clamped to the screen range.
    function logic [15:0] map_axis(logic signed [31:0] a, logic signed [31:0] b,
                                   logic signed [31:0] c, logic [15:0] u, logic [15:0] v);
      longint acc;
      acc = longint'(a) * longint'(u) + longint'(b) * longint'(v) + longint'(c);
      acc = acc >>> 16;
      if (acc < 0) return 16'h0000;
      if (acc > 65535) return 16'hFFFF;
      return 16'(acc);
    endfunction

    function void predict_snapshot(tct_pkg::tct_req_t ev);
      int                sel;
      int                free_slot;
      int                live;
      int                k;
      tct_pkg::tct_rsp_t rsp;
      sel       = -1;
      free_slot = -1;
      live      = 0;
      k         = 0;
      rsp       = '0;
      rsp.last  = 1'b1;
      if (!enabled) begin
        rsp.status = tct_pkg::ST_DISABLED;
        expected_reports.push_back(rsp);
        return;
      end
      for (int i = 0; i < tct_pkg::NUM_SLOTS; i++) begin
        if (in_use[i] && slots[i].id == ev.finger_id) begin
          sel = i;
          break;
        end
        if (!in_use[i] && free_slot < 0) free_slot = i;
      end
      if (sel < 0) sel = free_slot;
      if (sel < 0) begin
        rsp.status = tct_pkg::ST_NO_ROOM;
        expected_reports.push_back(rsp);
        return;
      end
      // A release of an unknown id lands on the lowest free slot, which stays free.
      if (ev.touching) begin
        in_use[sel]         = 1'b1;
        slots[sel].id       = ev.finger_id;
        slots[sel].x        = map_axis(coef.xx, coef.xy, coef.xoff, ev.raw_x, ev.raw_y);
        slots[sel].y        = map_axis(coef.yx, coef.yy, coef.yoff, ev.raw_x, ev.raw_y);
        slots[sel].pressure = ev.pressure;
      end else begin
        in_use[sel] = 1'b0;
      end
      foreach (in_use[i]) live += int'(in_use[i]);
      if (live == 0) begin
        rsp.status = tct_pkg::ST_OK;
        expected_reports.push_back(rsp);
        return;
      end
      for (int i = 0; i < tct_pkg::NUM_SLOTS; i++) begin
        if (in_use[i]) begin
          k++;
          rsp.status       = tct_pkg::ST_OK;
          rsp.has_contact  = 1'b1;
          rsp.active_count = 4'(live);
          rsp.out_id       = slots[i].id;
          rsp.out_x        = slots[i].x;
          rsp.out_y        = slots[i].y;
          rsp.out_pressure = slots[i].pressure;
          rsp.last         = (k == live);
          expected_reports.push_back(rsp);
        end
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_report(tct_pkg::tct_rsp_t got);
      tct_pkg::tct_rsp_t want;
      if (expected_reports.size() == 0) begin
        $error("result %h arrived with no snapshot outstanding", got);
        failures++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("has_contact", want.has_contact, got.has_contact);
      compare_field("active_count", want.active_count, got.active_count);
      compare_field("out_id", want.out_id, got.out_id);
      compare_field("out_x", want.out_x, got.out_x);
      compare_field("out_y", want.out_y, got.out_y);
      compare_field("out_pressure", want.out_pressure, got.out_pressure);
      compare_field("last", want.last, got.last);
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic                       clk     = 1'b0;
  logic                       rst     = 1'b1;
  logic                       start   = 1'b0;
  logic                       busy;
  tct_pkg::tct_req_t          req     = '0;
  logic                       done;
  tct_pkg::tct_rsp_t          result;
  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [tct_pkg::ADDR_W-1:0] paddr   = '0;
  logic [31:0]                pwdata  = '0;
  logic [31:0]                prdata;
  logic                       pready;

  snapshot_scoreboard sb;
  int                 stall_cycles = 0;

  touch_contact_tracker u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.predict_snapshot(req);
      if (done) sb.check_report(result);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic tct_pkg::tct_req_t contact(logic [7:0] id, logic [15:0] x,
                                                logic [15:0] y, logic [11:0] p, logic down);
    tct_pkg::tct_req_t ev;
    ev.finger_id = id;
    ev.raw_x     = x;
    ev.raw_y     = y;
    ev.pressure  = p;
    ev.touching  = down;
    return ev;
  endfunction

  // Mostly pool ids so that contacts move and lift; the rest lift unknown ids.
  function automatic tct_pkg::tct_req_t random_event();
    tct_pkg::tct_req_t ev;
    ev.raw_x    = 16'($urandom);
    ev.raw_y    = 16'($urandom);
    ev.pressure = 12'($urandom);
    if ($urandom_range(9) == 0) ev.raw_x = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    if ($urandom_range(9) == 0) ev.raw_y = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    if ($urandom_range(99) < 8) begin
      ev.finger_id = 8'($urandom);
      ev.touching  = 1'b0;
    end else begin
      ev.finger_id = CONTACT_POOL[$urandom_range(11)];
      ev.touching  = ($urandom_range(99) < 60);
    end
    return ev;
  endfunction

  function automatic tct_pkg::cal_coef_t pick_calibration(cal_style_t style);
    tct_pkg::cal_coef_t c;
    case (style)
      CAL_NEAR_UNITY: begin
        c.xx   = 32'(65536 + int'($urandom_range(16384)) - 8192);
        c.xy   = 32'(int'($urandom_range(4096)) - 2048);
        c.xoff = 32'(int'($urandom_range(8388608)) - 4194304);
        c.yx   = 32'(int'($urandom_range(4096)) - 2048);
        c.yy   = 32'(65536 + int'($urandom_range(16384)) - 8192);
        c.yoff = 32'(int'($urandom_range(8388608)) - 4194304);
      end
      CAL_ALL_MAX: c = {6{32'h7FFF_FFFF}};
      CAL_ALL_MIN: c = {6{32'h8000_0000}};
      default: c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endcase
    return c;
  endfunction

  task automatic push_event(tct_pkg::tct_req_t ev);
    start <= 1'b1;
    req   <= ev;
    do @(posedge clk); while (busy);
  endtask

  task automatic run_event(tct_pkg::tct_req_t ev, int idle_pct);
    push_event(ev);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Waits past the last request until every snapshot is in and the block is quiet.
  task automatic wait_for_idle();
    do @(posedge clk); while (sb.pending() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic program_register(logic [tct_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
    logic [31:0] readback_want;
    readback_want = (idx == tct_pkg::REG_ENABLE) ? {31'b0, value[0]} : value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_register(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== readback_want) begin
      $error("register %0d: expected %0h, got %0h", idx, readback_want, prdata);
      sb.failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(tct_pkg::cal_coef_t c, bit en);
    program_register(tct_pkg::REG_CAL_XX, c.xx);
    program_register(tct_pkg::REG_CAL_XY, c.xy);
    program_register(tct_pkg::REG_CAL_XOFF, c.xoff);
    program_register(tct_pkg::REG_CAL_YX, c.yx);
    program_register(tct_pkg::REG_CAL_YY, c.yy);
    program_register(tct_pkg::REG_CAL_YOFF, c.yoff);
    program_register(tct_pkg::REG_ENABLE, {31'b0, en});
  endtask

  initial begin
    int idle_pct;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset calibration.
    run_event(contact(8'h5A, 16'h0100, 16'h0200, 12'h010, 1'b0), 0);
    run_event(contact(CONTACT_POOL[0], 16'h0000, 16'h0000, 12'h000, 1'b1), 0);
    run_event(contact(CONTACT_POOL[1], 16'hFFFF, 16'hFFFF, 12'hFFF, 1'b1), 0);
    run_event(contact(CONTACT_POOL[0], 16'd1234, 16'd4321, 12'h7FF, 1'b1), 0);
    run_event(contact(CONTACT_POOL[1], 16'h0000, 16'h0000, 12'h000, 1'b0), 0);
    run_event(contact(CONTACT_POOL[0], 16'h0000, 16'h0000, 12'h000, 1'b0), 0);
    for (int i = 0; i < tct_pkg::NUM_SLOTS; i++) begin
      run_event(contact(CONTACT_POOL[i], 16'($urandom), 16'($urandom), 12'($urandom), 1'b1), 0);
    end
    // Full table: a new touch and a lift of an unknown id both find no room.
    run_event(contact(CONTACT_POOL[10], 16'h1000, 16'h2000, 12'h123, 1'b1), 0);
    run_event(contact(CONTACT_POOL[11], 16'h1000, 16'h2000, 12'h123, 1'b0), 0);
    run_event(contact(CONTACT_POOL[2], 16'h0000, 16'h0000, 12'h000, 1'b0), 0);
    run_event(contact(CONTACT_POOL[10], 16'hABCD, 16'h1357, 12'h9A5, 1'b1), 0);
    start <= 1'b0;
    wait_for_idle();

    program_register(tct_pkg::REG_ENABLE, 32'd0);
    run_event(contact(CONTACT_POOL[3], 16'h4444, 16'h5555, 12'h666, 1'b1), 0);
    run_event(contact(CONTACT_POOL[4], 16'h0000, 16'h0000, 12'h000, 1'b0), 0);
    start <= 1'b0;
    wait_for_idle();
    program_register(tct_pkg::REG_ENABLE, 32'd1);

    for (int phase = 0; phase < 9; phase++) begin
      // The receiver cannot stall; phases with phase % 4 of 0 or 2 run without sender gaps.
      case (phase % 4)
        1:       idle_pct = 82;
        3:       idle_pct = 36;
        default: idle_pct = 0;
      endcase
      apply_settings(pick_calibration(cal_style_t'(phase % 4)), phase != 6);
      repeat ((phase == 6) ? 12 : 52) run_event(random_event(), idle_pct);
      start <= 1'b0;
      wait_for_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
